FILE: rtl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package qvr_pkg;

  // Quaternion registers are Q1.x signed, 16 bits
  localparam int unsigned REG_W = 16;
  // Products of two register values
  localparam int unsigned PROD_W = 2 * REG_W;
  // Rotation matrix entries: 2 * (a*b - c*d) needs two bits above a product
  localparam int unsigned MAT_W = PROD_W + 2;
  // Rotated components
  localparam int unsigned OUT_W = 18;
  localparam int unsigned OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam int signed OUT_MAX = 131071;
  localparam int signed OUT_MIN = -131072;

  localparam int unsigned VEC_WIDTH_DEF = 16;
  localparam int unsigned QUAT_FRAC_BITS_DEF = 14;

  // Configuration register index
  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } qvr_reg_e;

  // Pairwise products of the quaternion components
  typedef struct packed {
    logic signed [PROD_W-1:0] ww;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] wz;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] wy;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] wx;
  } quat_prod_t;

  // Rotation matrix, row-major: entry r*3+c
  typedef logic [8:0][MAT_W-1:0] mat_t;

endpackage : qvr_pkg

`default_nettype wire

FILE: rtl/qvr_quat_mat.sv
// Quaternion configuration registers and the first two pipeline stages:
// pairwise quaternion products, then the 3x3 rotation matrix.
// Depends on qvr_pkg.
`default_nettype none

module qvr_quat_mat #(
  parameter int unsigned VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int unsigned QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  qvr_pkg::qvr_reg_e            cfg_idx_i,
  input  wire [qvr_pkg::REG_W-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [2:0][VEC_WIDTH-1:0]     in_vec_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output qvr_pkg::mat_t                out_mat_o,
  output logic [2:0][VEC_WIDTH-1:0]    out_vec_o
);
  import qvr_pkg::*;

  localparam logic [REG_W-1:0] QW_RESET = REG_W'(64'd1 << QUAT_FRAC_BITS);

  logic signed [REG_W-1:0] qw_q, qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q <= QW_RESET;
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUAT_W: qw_q <= cfg_data_i;
        REG_QUAT_X: qx_q <= cfg_data_i;
        REG_QUAT_Y: qy_q <= cfg_data_i;
        REG_QUAT_Z: qz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: quaternion products
  logic                          v1_q;
  logic                          rdy1;
  quat_prod_t                    prod_d, prod_q;
  logic [2:0][VEC_WIDTH-1:0]     vec1_q;

  // Stage 2: matrix
  logic                          v2_q;
  logic                          rdy2;
  mat_t                          mat_d, mat_q;
  logic [2:0][VEC_WIDTH-1:0]     vec2_q;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    prod_d.ww = qw_q * qw_q;
    prod_d.xx = qx_q * qx_q;
    prod_d.yy = qy_q * qy_q;
    prod_d.zz = qz_q * qz_q;
    prod_d.xy = qx_q * qy_q;
    prod_d.wz = qw_q * qz_q;
    prod_d.xz = qx_q * qz_q;
    prod_d.wy = qw_q * qy_q;
    prod_d.yz = qy_q * qz_q;
    prod_d.wx = qw_q * qx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod_q <= prod_d;
      vec1_q <= in_vec_i;
    end
  end

  always_comb begin
    logic signed [MAT_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    ww = MAT_W'(prod_q.ww);
    xx = MAT_W'(prod_q.xx);
    yy = MAT_W'(prod_q.yy);
    zz = MAT_W'(prod_q.zz);
    xy = MAT_W'(prod_q.xy);
    wz = MAT_W'(prod_q.wz);
    xz = MAT_W'(prod_q.xz);
    wy = MAT_W'(prod_q.wy);
    yz = MAT_W'(prod_q.yz);
    wx = MAT_W'(prod_q.wx);
    mat_d[0] = ww + xx - yy - zz;
    mat_d[1] = (xy - wz) <<< 1;
    mat_d[2] = (xz + wy) <<< 1;
    mat_d[3] = (xy + wz) <<< 1;
    mat_d[4] = ww - xx + yy - zz;
    mat_d[5] = (yz - wx) <<< 1;
    mat_d[6] = (xz - wy) <<< 1;
    mat_d[7] = (yz + wx) <<< 1;
    mat_d[8] = ww - xx - yy + zz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      mat_q  <= mat_d;
      vec2_q <= vec1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_mat_o   = mat_q;
  assign out_vec_o   = vec2_q;

  a_cfg_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_QUAT_X) |=> qx_q == $past(cfg_data_i))
    else $error("quat_x register missed a write");

  a_stage2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !out_ready_i |=> v2_q && $stable(mat_q) && $stable(vec2_q))
    else $error("matrix stage changed while stalled");

endmodule : qvr_quat_mat

`default_nettype wire

FILE: rtl/qvr_mat_vec.sv
// Matrix times vector: stage 3 forms the nine full-precision products,
// stage 4 sums each row, adds half an LSB and shifts. Depends on qvr_pkg.
`default_nettype none

module qvr_mat_vec #(
  parameter int unsigned VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int unsigned QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int unsigned SUM_W          = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  qvr_pkg::mat_t                in_mat_i,
  input  wire [2:0][VEC_WIDTH-1:0]     in_vec_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [2:0][SUM_W-1:0]        out_sum_o
);
  import qvr_pkg::*;

  localparam int unsigned PW = MAT_W + VEC_WIDTH;
  localparam int unsigned SH = 2 * QUAT_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (SH - 1);

  logic                    v3_q, v4_q;
  logic                    rdy3, rdy4;
  logic signed [PW-1:0]    p_d [9];
  logic signed [PW-1:0]    p_q [9];
  logic [2:0][SUM_W-1:0]   sum_d, sum_q;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign in_ready_o = rdy3;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_d[r*3+c] = PW'($signed(in_mat_i[r*3+c])) * PW'($signed(in_vec_i[c]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      p_q <= p_d;
    end
  end

  // Round to nearest, ties toward plus infinity: add half, then floor
  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = SUM_W'(p_q[r*3]) + SUM_W'(p_q[r*3+1]) + SUM_W'(p_q[r*3+2]) + HALF;
      sum_d[r] = acc >>> SH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_sum_o   = sum_q;

  a_stage4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_ready_i |=> v4_q && $stable(sum_q))
    else $error("row sum stage changed while stalled");

endmodule : qvr_mat_vec

`default_nettype wire

FILE: rtl/qvr_sat.sv
// Output stage: clip each rounded row sum to 18 bits signed, flag clipping,
// and hold the result for the master side. Depends on qvr_pkg.
`default_nettype none

module qvr_sat #(
  parameter int unsigned SUM_W = 64
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire [2:0][SUM_W-1:0]            in_sum_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [2:0][qvr_pkg::OUT_W-1:0]  out_rot_o,
  output logic                            out_sat_o
);
  import qvr_pkg::*;

  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SMIN = SUM_W'(OUT_MIN);
  localparam logic [OUT_W-1:0] RMAX = OUT_W'(OUT_MAX);
  localparam logic [OUT_W-1:0] RMIN = OUT_W'(OUT_MIN);

  logic                    v5_q;
  logic                    rdy5;
  logic [2:0][OUT_W-1:0]   rot_d, rot_q;
  logic                    sat_d, sat_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign in_ready_o = rdy5;

  always_comb begin
    sat_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if ($signed(in_sum_i[c]) > SMAX) begin
        rot_d[c] = RMAX;
        sat_d    = 1'b1;
      end else if ($signed(in_sum_i[c]) < SMIN) begin
        rot_d[c] = RMIN;
        sat_d    = 1'b1;
      end else begin
        rot_d[c] = in_sum_i[c][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && in_valid_i) begin
      rot_q <= rot_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_rot_o   = rot_q;
  assign out_sat_o   = sat_q;

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && sat_q |->
      rot_q[0] == RMAX || rot_q[0] == RMIN || rot_q[1] == RMAX ||
      rot_q[1] == RMIN || rot_q[2] == RMAX || rot_q[2] == RMIN)
    else $error("saturation flag set with no component at a limit");

endmodule : qvr_sat

`default_nettype wire

FILE: rtl/quaternion_vector_rotation_unit.sv
// Quaternion vector rotation unit: top level of the five-stage pipeline.
// Instantiates qvr_quat_mat, qvr_mat_vec and qvr_sat; depends on qvr_pkg.
//
// Rotates each 3-D vector on the slave stream by the quaternion in the four
// configuration registers (w, x, y, z in signed Q1.14, reset to identity)
// and returns the vector part of q*(0,v)*conj(q), rounded to nearest with
// ties toward plus infinity and clipped to 18 bits signed; tuser flags
// clipping. One vector is accepted per clock while the master side does not
// stall, and its result passes through every register stage in order before
// it is valid on the master side. The five register stages are: quaternion
// products, rotation matrix, matrix-vector multiply, row sum and round, clip.
// Each stage has its own valid bit and stalls only when the stage after it is
// full, so a stalled master side backs up the pipeline one stage at a time.
// Write the quaternion only while no vector is in flight; the new value
// applies to the next accepted vector.
`default_nettype none

module quaternion_vector_rotation_unit #(
  parameter int unsigned VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int unsigned QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration
  input  wire                                cfg_we_i,
  input  qvr_pkg::qvr_reg_e                  cfg_idx_i,
  input  wire [qvr_pkg::REG_W-1:0]           cfg_data_i,
  // Slave stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // vec_x, vec_y, vec_z (VEC_WIDTH each), zero pad to bytes
  input  wire [((3*VEC_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // Master stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // rot_x[17:0], rot_y[35:18], rot_z[53:36], zero pad
  output logic [qvr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // saturated
  output logic                               m_axis_tuser
);
  import qvr_pkg::*;

  localparam int unsigned PW    = MAT_W + VEC_WIDTH;
  localparam int unsigned SH    = 2 * QUAT_FRAC_BITS;
  localparam int unsigned SUM_W = (PW + 2 > SH + 2) ? PW + 2 : SH + 2;

  logic [2:0][VEC_WIDTH-1:0] in_vec;
  logic [2:0][VEC_WIDTH-1:0] mat_vec;
  mat_t                      mat;
  logic                      mat_valid, mat_ready;
  logic [2:0][SUM_W-1:0]     sum;
  logic                      sum_valid, sum_ready;
  logic [2:0][OUT_W-1:0]     rot;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_vec[c] = s_axis_tdata[c*VEC_WIDTH +: VEC_WIDTH];
    end
  end

  qvr_quat_mat #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_quat_mat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_vec_i    (in_vec),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_mat_o   (mat),
    .out_vec_o   (mat_vec)
  );

  qvr_mat_vec #(
    .VEC_WIDTH      (VEC_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .SUM_W          (SUM_W)
  ) u_mat_vec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .in_mat_i    (mat),
    .in_vec_i    (mat_vec),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_sum_o   (sum)
  );

  qvr_sat #(
    .SUM_W (SUM_W)
  ) u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_sum_i    (sum),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rot_o   (rot),
    .out_sat_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 3 * OUT_W)'(0), rot[2], rot[1], rot[0]};

  // Backpressure at the input can only come from a full, stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled output");

endmodule : quaternion_vector_rotation_unit

`default_nettype wire

FILE: verif/qvr_rotation_checker.sv
// Scoreboard for the quaternion vector rotation unit: mirrors the quaternion
// registers, predicts each rotated vector and compares the master stream.
// Depends on qvr_pkg for register indexes and output widths.
`timescale 1ns / 1ps

module qvr_rotation_checker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  qvr_pkg::qvr_reg_e                  cfg_idx_i,
  input  wire [qvr_pkg::REG_W-1:0]           cfg_data_i,
  input  wire                                s_axis_tvalid,
  input  wire                                s_axis_tready,
  // vec_x, vec_y, vec_z (16 bits each)
  input  wire [47:0]                         s_axis_tdata,
  input  wire                                m_axis_tvalid,
  input  wire                                m_axis_tready,
  // rot_x[17:0], rot_y[35:18], rot_z[53:36], zero pad
  input  wire [qvr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // saturated
  input  wire                                m_axis_tuser,
  output int                                 mismatches_o,
  output int                                 in_flight_o
);
  import qvr_pkg::*;

  localparam int unsigned VEC_W = VEC_WIDTH_DEF;
  localparam int unsigned ROUND_SHIFT = 2 * QUAT_FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [OUT_W-1:0] rot_x;
    logic signed [OUT_W-1:0] rot_y;
    logic signed [OUT_W-1:0] rot_z;
    logic                    saturated;
  } rotated_vec_t;

  rotated_vec_t            expected_rot_q[$];
  logic signed [REG_W-1:0] quat [4];
  int                      errs;

  // Exact row sum, then add half and floor: ties go toward plus infinity
  function automatic longint row_round(input longint m0, input longint m1, input longint m2,
                                       input longint a, input longint b, input longint c);
    longint acc;
    acc = m0 * a + m1 * b + m2 * c;
    return (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
  endfunction

  function automatic logic [OUT_W-1:0] clip_component(input longint v, output bit clipped);
    clipped = 1'b0;
    if (v > OUT_MAX) begin
      v = OUT_MAX;
      clipped = 1'b1;
    end
    if (v < OUT_MIN) begin
      v = OUT_MIN;
      clipped = 1'b1;
    end
    return v[OUT_W-1:0];
  endfunction

  // Vector part of q*(0,v)*conj(q), taken as M*v with M quadratic in q
  function automatic rotated_vec_t rotate_vector(input logic [47:0] vec);
    longint w, x, y, z, vx, vy, vz;
    longint ww, xx, yy, zz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    bit c0, c1, c2;
    rotated_vec_t r;
    w = quat[REG_QUAT_W];
    x = quat[REG_QUAT_X];
    y = quat[REG_QUAT_Y];
    z = quat[REG_QUAT_Z];
    vx = $signed(vec[VEC_W-1:0]);
    vy = $signed(vec[2*VEC_W-1:VEC_W]);
    vz = $signed(vec[3*VEC_W-1:2*VEC_W]);
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    m00 = ww + xx - yy - zz;
    m11 = ww - xx + yy - zz;
    m22 = ww - xx - yy + zz;
    m01 = 2 * (x * y - w * z);
    m10 = 2 * (x * y + w * z);
    m02 = 2 * (x * z + w * y);
    m20 = 2 * (x * z - w * y);
    m12 = 2 * (y * z - w * x);
    m21 = 2 * (y * z + w * x);
    r.rot_x = clip_component(row_round(m00, m01, m02, vx, vy, vz), c0);
    r.rot_y = clip_component(row_round(m10, m11, m12, vx, vy, vz), c1);
    r.rot_z = clip_component(row_round(m20, m21, m22, vx, vy, vz), c2);
    r.saturated = c0 | c1 | c2;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rotated_vec_t want;
    if (!rst_ni) begin
      quat[REG_QUAT_W] = 16'sd1 <<< QUAT_FRAC_BITS_DEF;
      quat[REG_QUAT_X] = '0;
      quat[REG_QUAT_Y] = '0;
      quat[REG_QUAT_Z] = '0;
      expected_rot_q.delete();
      errs = 0;
      mismatches_o <= 0;
      in_flight_o <= 0;
    end else begin
      // Retire the oldest expectation before queueing this edge's input
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rot_q.size() == 0) begin
          $display("%0t: result %h with nothing expected", $time, m_axis_tdata);
          errs++;
        end else begin
          want = expected_rot_q.pop_front();
          check_field("rot_x", want.rot_x, $signed(m_axis_tdata[OUT_W-1:0]));
          check_field("rot_y", want.rot_y, $signed(m_axis_tdata[2*OUT_W-1:OUT_W]));
          check_field("rot_z", want.rot_z, $signed(m_axis_tdata[3*OUT_W-1:2*OUT_W]));
          check_field("saturated", want.saturated, m_axis_tuser);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_rot_q.push_back(rotate_vector(s_axis_tdata));
      if (cfg_we_i)
        quat[cfg_idx_i] = cfg_data_i;
      mismatches_o <= errs;
      in_flight_o <= expected_rot_q.size();
    end
  end

endmodule

FILE: verif/quaternion_vector_rotation_unit_tb.sv
// Top of the rotation unit testbench: clock, reset, quaternion writes and
// randomly paced vector stimulus and result back-pressure.
// Depends on qvr_pkg, the rotation unit and qvr_rotation_checker.
`timescale 1ns / 1ps

module quaternion_vector_rotation_unit_tb;
  import qvr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  qvr_reg_e               cfg_idx_i = REG_QUAT_W;
  logic [REG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [47:0]            s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int mismatch_count;
  int vectors_in_flight;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  quaternion_vector_rotation_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  qvr_rotation_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatch_count),
    .in_flight_o   (vectors_in_flight)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Keep tvalid high from the previous transfer when no gap is drawn
  task automatic send_vec(input logic [15:0] vx, input logic [15:0] vy, input logic [15:0] vz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {vz, vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the input until every rotated vector has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (vectors_in_flight != 0) @(posedge clk_i);
  endtask

  task automatic set_quat(input logic [15:0] qw, input logic [15:0] qx,
                          input logic [15:0] qy, input logic [15:0] qz);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_QUAT_W;
    cfg_data_i <= qw;
    @(posedge clk_i);
    cfg_idx_i <= REG_QUAT_X;
    cfg_data_i <= qx;
    @(posedge clk_i);
    cfg_idx_i <= REG_QUAT_Y;
    cfg_data_i <= qy;
    @(posedge clk_i);
    cfg_idx_i <= REG_QUAT_Z;
    cfg_data_i <= qz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random direction scaled to unit length in Q1.14
  task automatic set_unit_quat();
    int  a, b, c, d;
    real n;
    a = $urandom_range(0, 32768) - 16384;
    b = $urandom_range(0, 32768) - 16384;
    c = $urandom_range(0, 32768) - 16384;
    d = $urandom_range(0, 32768) - 16384;
    n = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c + real'(d) * d);
    if (n < 1.0)
      set_quat(16'd16384, 16'd0, 16'd0, 16'd0);
    else
      set_quat(16'($rtoi(a * 16384.0 / n)), 16'($rtoi(b * 16384.0 / n)),
               16'($rtoi(c * 16384.0 / n)), 16'($rtoi(d * 16384.0 / n)));
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_vectors(input int count);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && $urandom_range(0, 3) == 0)
        drain();
      send_vec(rand_comp(), rand_comp(), rand_comp());
    end
    no_idle = 1'b0;
  endtask

  initial begin : sink
    int stall;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity quaternion straight out of reset
    send_vec(16'h0000, 16'h0000, 16'h0000);
    send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    send_vec(16'h7FFF, 16'h8000, 16'h0001);
    send_vec(16'hFFFF, 16'h0001, 16'hFFFF);
    random_vectors($urandom_range(50, 100));

    // Half on every component: the rotation permutes the axes, so every result is exact
    set_quat(16'd8192, 16'd8192, 16'd8192, 16'd8192);
    send_vec(16'h0001, 16'h0000, 16'h0000);
    send_vec(16'hFFFF, 16'h0000, 16'h0000);
    send_vec(16'h0000, 16'h0001, 16'h0000);
    send_vec(16'h0000, 16'hFFFF, 16'h0000);
    send_vec(16'h0001, 16'h0001, 16'h0001);
    send_vec(16'hFFFD, 16'h0005, 16'hFFF9);
    random_vectors($urandom_range(50, 100));

    // Non-unit quaternions drive the outputs into clipping
    set_quat(16'd16384, 16'd16384, 16'd16384, 16'd16384);
    send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    send_vec(16'h7FFF, 16'h8000, 16'h7FFF);
    send_vec(16'h0001, 16'h0001, 16'h0001);
    random_vectors($urandom_range(50, 100));

    set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    random_vectors($urandom_range(50, 100));

    set_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    random_vectors($urandom_range(50, 100));

    // Quarter turn about x
    set_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
    random_vectors($urandom_range(50, 100));

    set_quat(16'd0, 16'd0, 16'd0, 16'd0);
    random_vectors($urandom_range(50, 100));

    set_quat(-16'sd16384, 16'd0, 16'd0, 16'd0);
    random_vectors($urandom_range(50, 100));

    for (int p = 0; p < 12; p++) begin
      if (p % 2 == 0)
        set_unit_quat();
      else
        set_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_vectors($urandom_range(50, 100));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/qvr_pkg.sv
rtl/qvr_quat_mat.sv
rtl/qvr_mat_vec.sv
rtl/qvr_sat.sv
rtl/quaternion_vector_rotation_unit.sv
verif/qvr_rotation_checker.sv
verif/quaternion_vector_rotation_unit_tb.sv
